@@ rtl/core/tcc_pkg.sv @@
// Shared types, widths and constants for the timestamp continuity corrector.
// Used by every module in rtl/core; depends on nothing else.
package tcc_pkg;

    // Field widths
    localparam int PTS_BITS    = 48;
    localparam int STAMP_BITS  = 48;
    localparam int JUMP_BITS   = 24;
    localparam int TRAIN_BITS  = 4;
    localparam int MARGIN_BITS = 6;
    localparam int RUN_BITS    = 3;

    // Average gap: signed fixed point with 8 fraction bits
    localparam int AVG_BITS  = 34;
    localparam int FRAC_BITS = 8;

    // Derived datapath widths
    localparam int GAP_BITS   = STAMP_BITS + 1;
    localparam int SGAP_BITS  = JUMP_BITS + 1;
    localparam int MUL_A_BITS = AVG_BITS;
    localparam int MUL_B_BITS = 8;
    localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;
    localparam int LHS_BITS   = MUL_P_BITS + FRAC_BITS;
    localparam int FULL_BITS  = AVG_BITS + TRAIN_BITS;
    localparam int DIV_D_BITS = TRAIN_BITS;
    localparam int RND_BITS   = AVG_BITS - FRAC_BITS + 2;
    localparam int PRED_BITS  = ((STAMP_BITS > PTS_BITS) ? STAMP_BITS : PTS_BITS) + 2;

    // Configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = JUMP_BITS;

    localparam logic [JUMP_BITS-1:0]   JUMP_RESET   = JUMP_BITS'(200000);
    localparam logic [TRAIN_BITS-1:0]  TRAIN_RESET  = TRAIN_BITS'(5);
    localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = MARGIN_BITS'(10);
    localparam logic [RUN_BITS-1:0]    RUN_RESET    = RUN_BITS'(2);

    // One hundred percent, as a multiplier operand
    localparam logic [MUL_B_BITS-1:0] PERCENT_FULL = MUL_B_BITS'(100);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_JUMP_LIMIT,
        CFG_TRAIN_FRAMES,
        CFG_MARGIN_PERCENT,
        CFG_MAX_REWRITES
    } cfg_index_t;

    typedef struct packed {
        logic [JUMP_BITS-1:0]   jump_limit;
        logic [TRAIN_BITS-1:0]  train_frames;
        logic [MARGIN_BITS-1:0] margin_percent;
        logic [RUN_BITS-1:0]    max_rewrites;
    } cfg_t;

    typedef struct packed {
        logic                       req_type;
        logic                       enable;
        logic signed [PTS_BITS-1:0] pts_in;
    } in_beat_t;

    typedef struct packed {
        logic signed [PTS_BITS-1:0] pts_out;
        logic                       rewritten;
        logic                       locked;
    } out_beat_t;

    typedef struct packed {
        logic idle;
        logic done;
    } core_stat_t;

    typedef struct packed {
        logic                         start;
        logic signed [MUL_A_BITS-1:0] mcand;
        logic [MUL_B_BITS-1:0]        mplier;
    } mul_req_t;

    typedef struct packed {
        logic                  start;
        logic [FULL_BITS-1:0]  dividend;
        logic [DIV_D_BITS-1:0] divisor;
    } div_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_TRAIN_WAIT,
        ST_TRAIN_DIV,
        ST_DIV_WAIT,
        ST_GAP_WAIT,
        ST_UP_WAIT,
        ST_LO_WAIT,
        ST_DECIDE,
        ST_DONE
    } core_state_t;

endpackage

@@ rtl/core/tcc_serial_mul.sv @@
// Shift-add multiplier: signed multiplicand times unsigned 8-bit factor,
// one factor bit per cycle. Depends on tcc_pkg.
module tcc_serial_mul (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tcc_pkg::mul_req_t                     req,
    output logic                                  busy,
    output logic signed [tcc_pkg::MUL_P_BITS-1:0] product
);
    import tcc_pkg::*;

    localparam int CNT_BITS = $clog2(MUL_B_BITS + 1);

    logic signed [MUL_P_BITS-1:0] acc_reg, acc_next;
    logic signed [MUL_P_BITS-1:0] addend_reg, addend_next;
    logic [MUL_B_BITS-1:0]        mplier_reg, mplier_next;
    logic [CNT_BITS-1:0]          count_reg, count_next;

    // Load on start, then add the shifted multiplicand for each set factor bit.
    always_comb
    begin
        acc_next    = acc_reg;
        addend_next = addend_reg;
        mplier_next = mplier_reg;
        count_next  = count_reg;
        if (req.start)
        begin
            acc_next    = '0;
            addend_next = MUL_P_BITS'(req.mcand);
            mplier_next = req.mplier;
            count_next  = CNT_BITS'(MUL_B_BITS);
        end
        else if (count_reg != '0)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + addend_reg;
            end
            addend_next = addend_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            count_next  = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        addend_reg <= addend_next;
        mplier_reg <= mplier_next;
    end

    assign busy    = (count_reg != '0);
    assign product = acc_reg;

endmodule

@@ rtl/core/tcc_serial_div.sv @@
// Restoring divider for the training average: one quotient bit per cycle,
// unsigned dividend by a small unsigned divisor. Depends on tcc_pkg.
module tcc_serial_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tcc_pkg::div_req_t              req,
    output logic                           busy,
    output logic [tcc_pkg::FULL_BITS-1:0]  quotient
);
    import tcc_pkg::*;

    localparam int CNT_BITS = $clog2(FULL_BITS + 1);

    // The work register shifts dividend bits out at the top and quotient bits in below.
    logic [FULL_BITS-1:0]  work_reg, work_next;
    logic [DIV_D_BITS-1:0] rem_reg, rem_next;
    logic [DIV_D_BITS-1:0] div_reg, div_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [DIV_D_BITS:0]   trial;
    logic [DIV_D_BITS:0]   trial_diff;
    logic                  q_bit;

    // One trial subtraction per cycle on the narrow partial remainder.
    always_comb
    begin
        trial      = {rem_reg, work_reg[FULL_BITS-1]};
        trial_diff = trial - {1'b0, div_reg};
        q_bit      = (trial >= {1'b0, div_reg});
        work_next  = work_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        count_next = count_reg;
        if (req.start)
        begin
            work_next  = req.dividend;
            rem_next   = '0;
            div_next   = req.divisor;
            count_next = CNT_BITS'(FULL_BITS);
        end
        else if (count_reg != '0)
        begin
            rem_next   = q_bit ? trial_diff[DIV_D_BITS-1:0] : trial[DIV_D_BITS-1:0];
            work_next  = {work_reg[FULL_BITS-2:0], q_bit};
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign busy     = (count_reg != '0);
    assign quotient = work_reg;

endmodule

@@ rtl/core/tcc_core.sv @@
// Sequencer and history state of the corrector: gap measurement, training
// average, band check and prediction. Depends on tcc_pkg, tcc_serial_mul, tcc_serial_div.
module tcc_core (
    input  logic                clk,
    input  logic                rst_n,
    input  tcc_pkg::cfg_t       cfg,
    input  logic                start,
    input  tcc_pkg::in_beat_t   item,
    input  logic                take,
    output tcc_pkg::core_stat_t stat,
    output tcc_pkg::out_beat_t  result
);
    import tcc_pkg::*;

    localparam logic signed [PRED_BITS-1:0] PRED_PTS_MAX =
        {{(PRED_BITS-PTS_BITS+1){1'b0}}, {(PTS_BITS-1){1'b1}}};
    localparam logic signed [PRED_BITS-1:0] PRED_PTS_MIN =
        {{(PRED_BITS-PTS_BITS+1){1'b1}}, {(PTS_BITS-1){1'b0}}};
    localparam logic signed [PRED_BITS-1:0] PRED_ONE = PRED_BITS'(1);

    core_state_t state_reg, state_next;

    // Beat being worked on
    in_beat_t item_reg, item_next;

    // History state
    logic signed [STAMP_BITS-1:0] last_reg, last_next;
    logic [TRAIN_BITS-1:0]        count_reg, count_next;
    logic signed [AVG_BITS-1:0]   avg_reg, avg_next;
    logic [RUN_BITS-1:0]          run_reg, run_next;

    // Working values
    logic signed [SGAP_BITS-1:0]  gap_reg, gap_next;
    logic signed [FULL_BITS-1:0]  full_reg, full_next;
    logic signed [LHS_BITS-1:0]   lhs_reg, lhs_next;
    logic signed [MUL_P_BITS-1:0] up_reg, up_next;
    logic signed [MUL_P_BITS-1:0] lo_reg, lo_next;
    logic signed [RND_BITS-1:0]   rnd_reg, rnd_next;
    logic signed [PTS_BITS-1:0]   res_pts_reg, res_pts_next;
    logic                         res_rew_reg, res_rew_next;

    // Arithmetic units
    mul_req_t                     mul_req;
    logic                         mul_busy;
    logic signed [MUL_P_BITS-1:0] mul_product;
    div_req_t                     div_req;
    logic                         div_busy;
    logic [FULL_BITS-1:0]         div_quot;

    // Combinational helpers
    logic signed [STAMP_BITS-1:0] cur_stamp;
    logic signed [GAP_BITS-1:0]   gap;
    logic [GAP_BITS-1:0]          gap_mag;
    logic signed [SGAP_BITS-1:0]  gap_short;
    logic                         is_jump;
    logic                         in_train;
    logic                         locked;
    logic [FULL_BITS-1:0]         full_mag;
    logic [TRAIN_BITS-1:0]        divisor;
    logic [AVG_BITS-1:0]          quot_short;
    logic [AVG_BITS-1:0]          avg_mag;
    logic [AVG_BITS:0]            avg_rnd_sum;
    logic [RND_BITS-1:0]          rnd_mag;
    logic                         out_of_band;
    logic signed [PRED_BITS-1:0]  pred_base;
    logic signed [PRED_BITS-1:0]  pred_sum;
    logic signed [PTS_BITS-1:0]   pred_pts;
    logic [RUN_BITS-1:0]          run_inc;
    logic                         run_clear;

    tcc_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .busy    (mul_busy),
        .product (mul_product)
    );

    tcc_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    // Gap between the incoming stamp and the stored one, and the jump test.
    always_comb
    begin
        cur_stamp = STAMP_BITS'(item_reg.pts_in);
        gap       = GAP_BITS'(cur_stamp) - GAP_BITS'(last_reg);
        gap_mag   = gap[GAP_BITS-1] ? unsigned'(-gap) : unsigned'(gap);
        gap_short = gap[SGAP_BITS-1:0];
        is_jump   = (gap == '0) || (gap_mag > GAP_BITS'(cfg.jump_limit));
        in_train  = (count_reg < cfg.train_frames);
        locked    = (last_reg != '0) && (count_reg >= cfg.train_frames);
    end

    // Training average operands: magnitude plus half the divisor rounds to nearest.
    always_comb
    begin
        full_mag   = full_reg[FULL_BITS-1] ? unsigned'(-full_reg) : unsigned'(full_reg);
        divisor    = count_reg + TRAIN_BITS'(1);
        quot_short = div_quot[AVG_BITS-1:0];
    end

    // Average rounded to whole ticks, ties away from zero.
    always_comb
    begin
        avg_mag     = avg_reg[AVG_BITS-1] ? unsigned'(-avg_reg) : unsigned'(avg_reg);
        avg_rnd_sum = {1'b0, avg_mag} + (AVG_BITS+1)'(1 << (FRAC_BITS - 1));
        rnd_mag     = RND_BITS'(avg_rnd_sum >> FRAC_BITS);
    end

    // Band test, prediction with saturation and the rewrite run update.
    always_comb
    begin
        out_of_band = (lhs_reg > LHS_BITS'(up_reg)) || (lhs_reg < LHS_BITS'(lo_reg));
        pred_base   = PRED_BITS'(last_reg);
        if (pred_base > PRED_PTS_MAX)
        begin
            pred_base = PRED_PTS_MAX + PRED_ONE;
        end
        else if (pred_base < PRED_PTS_MIN)
        begin
            pred_base = PRED_PTS_MIN - PRED_ONE;
        end
        pred_sum = pred_base + PRED_BITS'(rnd_reg);
        if (pred_sum > PRED_PTS_MAX)
        begin
            pred_pts = PTS_BITS'(PRED_PTS_MAX);
        end
        else if (pred_sum < PRED_PTS_MIN)
        begin
            pred_pts = PTS_BITS'(PRED_PTS_MIN);
        end
        else
        begin
            pred_pts = PTS_BITS'(pred_sum);
        end
        run_inc   = run_reg + RUN_BITS'(1);
        run_clear = (run_inc >= cfg.max_rewrites) || (run_inc == '0);
    end

    // Sequencer: next state, unit requests and state updates.
    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        last_next    = last_reg;
        count_next   = count_reg;
        avg_next     = avg_reg;
        run_next     = run_reg;
        gap_next     = gap_reg;
        full_next    = full_reg;
        lhs_next     = lhs_reg;
        up_next      = up_reg;
        lo_next      = lo_reg;
        rnd_next     = rnd_reg;
        res_pts_next = res_pts_reg;
        res_rew_next = res_rew_reg;

        mul_req.start  = 1'b0;
        mul_req.mcand  = avg_reg;
        mul_req.mplier = MUL_B_BITS'(count_reg);
        div_req.start    = 1'b0;
        div_req.dividend = full_mag + FULL_BITS'(divisor >> 1);
        div_req.divisor  = divisor;

        stat.idle = 1'b0;
        stat.done = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                stat.idle = 1'b1;
                if (start)
                begin
                    item_next  = item;
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                res_pts_next = item_reg.pts_in;
                res_rew_next = 1'b0;
                state_next   = ST_DONE;
                if (item_reg.req_type)
                begin
                    // Flush: all history cleared, result is zero.
                    last_next    = '0;
                    count_next   = '0;
                    avg_next     = '0;
                    run_next     = '0;
                    res_pts_next = '0;
                end
                else if (!item_reg.enable)
                begin
                    // Passthrough frame: state is left alone.
                end
                else if (last_reg == '0)
                begin
                    last_next = cur_stamp;
                end
                else if (is_jump)
                begin
                    last_next  = cur_stamp;
                    count_next = '0;
                    avg_next   = '0;
                    run_next   = '0;
                end
                else if (in_train)
                begin
                    gap_next       = gap_short;
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = avg_reg;
                    mul_req.mplier = MUL_B_BITS'(count_reg);
                    state_next     = ST_TRAIN_WAIT;
                end
                else
                begin
                    gap_next       = gap_short;
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = MUL_A_BITS'(gap_short);
                    mul_req.mplier = PERCENT_FULL;
                    state_next     = ST_GAP_WAIT;
                end
            end

            ST_TRAIN_WAIT:
            begin
                if (!mul_busy)
                begin
                    full_next  = FULL_BITS'(mul_product)
                               + (FULL_BITS'(gap_reg) <<< FRAC_BITS);
                    state_next = ST_TRAIN_DIV;
                end
            end

            ST_TRAIN_DIV:
            begin
                div_req.start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end

            ST_DIV_WAIT:
            begin
                if (!div_busy)
                begin
                    avg_next   = full_reg[FULL_BITS-1] ? -signed'(quot_short)
                                                       : signed'(quot_short);
                    count_next = divisor;
                    last_next  = cur_stamp;
                    state_next = ST_DONE;
                end
            end

            ST_GAP_WAIT:
            begin
                if (!mul_busy)
                begin
                    lhs_next       = LHS_BITS'(mul_product) <<< FRAC_BITS;
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = avg_reg;
                    mul_req.mplier = PERCENT_FULL + MUL_B_BITS'(cfg.margin_percent);
                    state_next     = ST_UP_WAIT;
                end
            end

            ST_UP_WAIT:
            begin
                if (!mul_busy)
                begin
                    up_next        = mul_product;
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = avg_reg;
                    mul_req.mplier = PERCENT_FULL - MUL_B_BITS'(cfg.margin_percent);
                    state_next     = ST_LO_WAIT;
                end
            end

            ST_LO_WAIT:
            begin
                if (!mul_busy)
                begin
                    lo_next    = mul_product;
                    rnd_next   = avg_reg[AVG_BITS-1] ? -signed'(rnd_mag) : signed'(rnd_mag);
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                state_next = ST_DONE;
                if (out_of_band)
                begin
                    res_pts_next = pred_pts;
                    res_rew_next = 1'b1;
                    last_next    = STAMP_BITS'(pred_pts);
                    if (run_clear)
                    begin
                        count_next = '0;
                        avg_next   = '0;
                        run_next   = '0;
                    end
                    else
                    begin
                        run_next = run_inc;
                    end
                end
                else
                begin
                    run_next  = '0;
                    last_next = cur_stamp;
                end
            end

            ST_DONE:
            begin
                stat.done = 1'b1;
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            last_reg  <= '0;
            count_reg <= '0;
            avg_reg   <= '0;
            run_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            count_reg <= count_next;
            avg_reg   <= avg_next;
            run_reg   <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        gap_reg     <= gap_next;
        full_reg    <= full_next;
        lhs_reg     <= lhs_next;
        up_reg      <= up_next;
        lo_reg      <= lo_next;
        rnd_reg     <= rnd_next;
        res_pts_reg <= res_pts_next;
        res_rew_reg <= res_rew_next;
    end

    assign result.pts_out   = res_pts_reg;
    assign result.rewritten = res_rew_reg;
    assign result.locked    = locked;

endmodule

@@ rtl/core/timestamp_continuity_corrector.sv @@
// Top level: configuration registers, input handshake and output register.
// Depends on tcc_pkg and tcc_core.
// One beat at a time. Flush, passthrough, first-stamp and jump beats go straight from evaluation
// to done; checked frames wait on three 8-step serial multiplies and training frames on one
// multiply and the 38-step serial divider. The input opens again for the next beat when the
// result moves to the output register.
// Reset (rst_n low, asynchronous) empties history and restores register defaults.
module timestamp_continuity_corrector (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  tcc_pkg::in_beat_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output tcc_pkg::out_beat_t                   out_data,
    input  logic                                 cfg_we,
    input  logic [tcc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [tcc_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
    import tcc_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    core_stat_t core_stat;
    out_beat_t  core_result;
    out_beat_t  out_data_reg, out_data_next;
    logic       out_valid_reg, out_valid_next;
    logic       start;
    logic       take;

    // Register writes by index.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_JUMP_LIMIT:     cfg_next.jump_limit     = cfg_wdata[JUMP_BITS-1:0];
                CFG_TRAIN_FRAMES:   cfg_next.train_frames   = cfg_wdata[TRAIN_BITS-1:0];
                CFG_MARGIN_PERCENT: cfg_next.margin_percent = cfg_wdata[MARGIN_BITS-1:0];
                CFG_MAX_REWRITES:   cfg_next.max_rewrites   = cfg_wdata[RUN_BITS-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // Handshake: the core takes a beat when idle and hands its result over
    // once the output register is free or being emptied.
    assign in_ready = core_stat.idle;
    assign start    = in_valid && in_ready;
    assign take     = core_stat.done && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            out_data_next  = core_result;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    tcc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .start  (start),
        .item   (in_data),
        .take   (take),
        .stat   (core_stat),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.jump_limit     <= JUMP_RESET;
            cfg_reg.train_frames   <= TRAIN_RESET;
            cfg_reg.margin_percent <= MARGIN_RESET;
            cfg_reg.max_rewrites   <= RUN_RESET;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // An accepted beat keeps the input closed for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !in_ready)
        else $error("input reopened right after a beat was accepted");

    // A new result only appears after the core reported it finished.
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(core_stat.done))
        else $error("output went valid without a finished result");

    // A finished result blocks the input until it is handed over.
    a_done_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        core_stat.done && !take |=> !in_ready)
        else $error("input opened while a result was still held in the core");

endmodule

@@ sim/tb_timestamp_continuity_corrector.sv @@
// Self-checking testbench for timestamp_continuity_corrector: directed and random frame
// streams, checked beat by beat against a behavioral predictor of the corrector.
// Depends on tcc_pkg and the RTL under rtl/core.
module tb_timestamp_continuity_corrector;
    timeunit 1ns;
    timeprecision 1ps;
    import tcc_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 100;
    localparam int PRINT_LIMIT   = 40;

    localparam logic REQ_FRAME = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    localparam logic [PTS_BITS-1:0] PTS_TOP    = {1'b0, {(PTS_BITS-1){1'b1}}};
    localparam logic [PTS_BITS-1:0] PTS_BOTTOM = {1'b1, {(PTS_BITS-1){1'b0}}};
    localparam longint STAMP_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint STAMP_LO = -STAMP_HI - 1;
    localparam longint ONE_TICK = longint'(1) << FRAC_BITS;
    localparam longint PERCENT  = 100;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    in_beat_t                  in_data   = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    out_beat_t                 out_data;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

    // Register copies and history kept by the predictor
    longint                jump_max    = JUMP_RESET;
    longint                train_len   = TRAIN_RESET;
    longint                band_pct    = MARGIN_RESET;
    longint                rewrite_max = RUN_RESET;
    logic [STAMP_BITS-1:0] hist_stamp  = '0;
    longint                gaps_seen   = 0;
    longint                mean_gap    = 0;
    longint                rewrite_streak = 0;

    out_beat_t corrected_stamps[$];
    int        mismatches   = 0;
    int        results_seen = 0;
    int        idle_cycles  = 0;
    bit        steady       = 1'b0;

    timestamp_continuity_corrector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic longint sext_stamp(logic [PTS_BITS-1:0] v);
        logic signed [PTS_BITS-1:0] s;
        s = v;
        return s;
    endfunction

    // Division rounded to nearest, ties away from zero; d is positive.
    function automatic longint round_half_away(longint n, longint d);
        longint mag;
        longint q;
        mag = (n < 0) ? -n : n;
        q = (mag + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    function automatic void forget_history();
        gaps_seen      = 0;
        mean_gap       = 0;
        rewrite_streak = 0;
    endfunction

    function automatic logic is_locked();
        return (hist_stamp != '0) && (gaps_seen >= train_len);
    endfunction

    // Works out the corrected beat for one accepted input beat and updates the history.
    function automatic out_beat_t correct_stamp(in_beat_t b);
        out_beat_t r;
        longint    cur;
        longint    prev;
        longint    gap;
        longint    mag;
        longint    acc;
        longint    result;
        logic      rew;
        cur    = sext_stamp(b.pts_in);
        result = cur;
        rew    = 1'b0;
        if (b.req_type == REQ_FLUSH)
        begin
            hist_stamp = '0;
            forget_history();
            return '0;
        end
        if (!b.enable)
        begin
            r.pts_out   = b.pts_in;
            r.rewritten = 1'b0;
            r.locked    = is_locked();
            return r;
        end
        if (hist_stamp != '0)
        begin
            prev = sext_stamp(hist_stamp);
            gap  = cur - prev;
            mag  = (gap < 0) ? -gap : gap;
            if (gap == 0 || mag > jump_max)
                forget_history();
            else if (gaps_seen < train_len)
            begin
                // Still learning: fold this gap into the running mean
                acc       = mean_gap * gaps_seen + gap * ONE_TICK;
                gaps_seen = (gaps_seen + 1) & 15;
                mean_gap  = (gaps_seen == 0) ? 0 : round_half_away(acc, gaps_seen);
            end
            else
            begin
                // Band check against the learned mean, scaled to avoid fractions
                acc = gap * ONE_TICK * PERCENT;
                if (acc > mean_gap * (PERCENT + band_pct) ||
                    acc < mean_gap * (PERCENT - band_pct))
                begin
                    result = prev + round_half_away(mean_gap, ONE_TICK);
                    if (result > STAMP_HI)
                        result = STAMP_HI;
                    if (result < STAMP_LO)
                        result = STAMP_LO;
                    rew = 1'b1;
                    rewrite_streak = (rewrite_streak + 1) & 7;
                    if (rewrite_streak >= rewrite_max || rewrite_streak == 0)
                        forget_history();
                end
                else
                    rewrite_streak = 0;
            end
        end
        hist_stamp  = result[STAMP_BITS-1:0];
        r.pts_out   = result[PTS_BITS-1:0];
        r.rewritten = rew;
        r.locked    = is_locked();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Shared helpers
    // ------------------------------------------------------------------

    function automatic int draw_idle();
        return steady ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic logic [PTS_BITS-1:0] rand_stamp();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[PTS_BITS-1:0];
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch at result %0d: %s got %0d, want %0d",
                     results_seen, field, got, want);
    endtask

    // Offers one beat, holds it until accepted, then records its prediction.
    task automatic send_beat(logic req, logic en, logic [PTS_BITS-1:0] pts);
        in_beat_t b;
        int       idle;
        b.req_type = req;
        b.enable   = en;
        b.pts_in   = pts;
        idle = draw_idle();
        if (idle != 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge clk); while (!in_ready);
        corrected_stamps.push_back(correct_stamp(b));
    endtask

    // Drops valid and waits until every predicted beat has come back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (corrected_stamps.size() != 0);
    endtask

    // Writes all four registers on consecutive cycles while the block is idle.
    task automatic set_config(longint jl, longint tf, longint mp, longint mr);
        cfg_index_t               reg_id;
        logic [CFG_DATA_BITS-1:0] v;
        wait_idle();
        reg_id = reg_id.first();
        do
        begin
            case (reg_id)
                CFG_JUMP_LIMIT:
                begin
                    v = CFG_DATA_BITS'(jl);
                    jump_max = v[JUMP_BITS-1:0];
                end
                CFG_TRAIN_FRAMES:
                begin
                    v = CFG_DATA_BITS'(tf);
                    train_len = v[TRAIN_BITS-1:0];
                end
                CFG_MARGIN_PERCENT:
                begin
                    v = CFG_DATA_BITS'(mp);
                    band_pct = v[MARGIN_BITS-1:0];
                end
                default:
                begin
                    v = CFG_DATA_BITS'(mr);
                    rewrite_max = v[RUN_BITS-1:0];
                end
            endcase
            cfg_we    <= 1'b1;
            cfg_index <= reg_id;
            cfg_wdata <= v;
            @(posedge clk);
            reg_id = reg_id.next();
        end
        while (reg_id != reg_id.first());
        cfg_we <= 1'b0;
    endtask

    // A frame stream with a steady cadence and jitter, mixed with outliers,
    // repeated stamps, jumps, bypassed frames, flushes and random noise.
    task automatic run_stream(int n);
        logic [PTS_BITS-1:0] stamp;
        longint              gmax;
        longint              g;
        longint              span;
        longint              jit;
        longint              off;
        int                  k;
        case ($urandom_range(0, 3))
            0:       stamp = PTS_BITS'($urandom_range(1, 1 << 20));
            1:       stamp = rand_stamp();
            2:       stamp = PTS_TOP - PTS_BITS'($urandom_range(0, 1 << 20));
            default: stamp = PTS_BOTTOM + PTS_BITS'($urandom_range(0, 1 << 20));
        endcase
        gmax = (jump_max < 40000 || $urandom_range(0, 7) == 0) ? jump_max : 40000;
        g = $urandom_range(1, gmax);
        if ($urandom_range(0, 7) == 0)
            g = -g;
        span = (((g < 0) ? -g : g) * band_pct) / 300;
        send_beat(REQ_FRAME, 1'b1, stamp);
        repeat (n - 1)
        begin
            k = $urandom_range(0, 99);
            if (k < 78)
            begin
                jit = (span == 0) ? 0 : longint'($urandom_range(0, 2 * span)) - span;
                stamp = stamp + PTS_BITS'(g + jit);
                send_beat(REQ_FRAME, 1'b1, stamp);
            end
            else if (k < 85)
            begin
                stamp = stamp + PTS_BITS'(g);
                off = longint'($urandom_range(0, 2 * gmax)) - gmax;
                send_beat(REQ_FRAME, 1'b1, stamp + PTS_BITS'(off));
            end
            else if (k < 88)
                send_beat(REQ_FRAME, 1'b1, stamp);
            else if (k < 90)
            begin
                off = jump_max + 1 + $urandom_range(0, 1000);
                stamp = stamp + PTS_BITS'(($urandom_range(0, 1) == 0) ? off : -off);
                send_beat(REQ_FRAME, 1'b1, stamp);
            end
            else if (k < 94)
                send_beat(REQ_FRAME, 1'b0, rand_stamp());
            else if (k < 96)
                send_beat(REQ_FLUSH, 1'($urandom_range(0, 1)), rand_stamp());
            else
                send_beat(REQ_FRAME, 1'b1, rand_stamp());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Learn a 1000 tick cadence ending on a zero stamp, then check in-band,
    // bypass, two rewrites in a row, a repeated stamp and a jump.
    task automatic test_training_and_lock();
        for (int k = -5; k <= 0; k++)
            send_beat(REQ_FRAME, 1'b1, PTS_BITS'(k * 1000));
        send_beat(REQ_FRAME, 1'b1, PTS_BITS'(1000));
        send_beat(REQ_FRAME, 1'b1, PTS_BITS'(2000));
        send_beat(REQ_FRAME, 1'b0, PTS_TOP);
        send_beat(REQ_FRAME, 1'b1, PTS_BITS'(3500));
        send_beat(REQ_FRAME, 1'b1, PTS_BITS'(3300));
        send_beat(REQ_FRAME, 1'b1, PTS_BITS'(4000));
        send_beat(REQ_FRAME, 1'b1, PTS_BITS'(304000));
    endtask

    // Bypassed frames at the extremes of the stamp field, then flushes.
    task automatic test_passthrough_and_flush();
        send_beat(REQ_FRAME, 1'b0, '0);
        send_beat(REQ_FRAME, 1'b0, PTS_BOTTOM);
        send_beat(REQ_FRAME, 1'b0, '1);
        send_beat(REQ_FRAME, 1'b0, rand_stamp());
        send_beat(REQ_FLUSH, 1'b1, '1);
        send_beat(REQ_FLUSH, 1'b0, '0);
    endtask

    // Predictions past either end of the stamp range must clamp.
    task automatic test_saturation();
        set_config(JUMP_RESET, 1, MARGIN_RESET, RUN_RESET);
        send_beat(REQ_FRAME, 1'b1, PTS_TOP - PTS_BITS'(1500));
        send_beat(REQ_FRAME, 1'b1, PTS_TOP - PTS_BITS'(500));
        send_beat(REQ_FRAME, 1'b1, PTS_TOP - PTS_BITS'(600));
        send_beat(REQ_FLUSH, 1'b0, '0);
        send_beat(REQ_FRAME, 1'b1, PTS_BOTTOM + PTS_BITS'(1500));
        send_beat(REQ_FRAME, 1'b1, PTS_BOTTOM + PTS_BITS'(500));
        send_beat(REQ_FRAME, 1'b1, PTS_BOTTOM + PTS_BITS'(600));
    endtask

    // Register extremes, including training and rewrite limits of zero.
    task automatic test_settings();
        set_config(16777215, 15, 50, 7);
        run_stream(70);
        set_config(1, 1, 0, 1);
        run_stream(50);
        set_config(1000, 0, 25, 0);
        run_stream(50);
        set_config(JUMP_RESET, TRAIN_RESET, MARGIN_RESET, RUN_RESET);
        run_stream(60);
    endtask

    // Random settings, each followed by a stream; some streams run without idling.
    task automatic test_random_streams();
        int     sent;
        int     n;
        longint jl;
        sent = 0;
        while (sent < 800)
        begin
            n = $urandom_range(20, 120);
            case ($urandom_range(0, 5))
                0:       jl = 1;
                1:       jl = 16777215;
                2:       jl = $urandom_range(1, 16777215);
                default: jl = $urandom_range(100, 300000);
            endcase
            set_config(jl, $urandom_range(1, 15), $urandom_range(0, 50), $urandom_range(1, 7));
            steady = ($urandom_range(0, 3) == 0);
            run_stream(n);
            sent += n;
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, each beat checked against the oldest prediction
    // ------------------------------------------------------------------
    initial
    begin : result_checker
        out_beat_t got;
        out_beat_t want;
        int        stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got = out_data;
                results_seen++;
                if (corrected_stamps.size() == 0)
                    report_mismatch("beat with nothing pending, pts_out", got.pts_out, 0);
                else
                begin
                    want = corrected_stamps.pop_front();
                    if (got.pts_out !== want.pts_out)
                        report_mismatch("pts_out", got.pts_out, want.pts_out);
                    if (got.rewritten !== want.rewritten)
                        report_mismatch("rewritten", got.rewritten, want.rewritten);
                    if (got.locked !== want.locked)
                        report_mismatch("locked", got.locked, want.locked);
                end
                stall = draw_idle();
                if (stall != 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                    out_ready <= 1'b1;
                end
            end
        end
    end

    // Watchdog: too long without any beat on either side ends the run.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Sequence of tests
    initial
    begin : regression
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_training_and_lock();
        test_passthrough_and_flush();
        test_saturation();
        test_settings();
        test_random_streams();
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && corrected_stamps.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
